// ----- src/hpcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcc_pkg
// Shared widths, types and helpers for the plane corner / containment block.
// ----------------------------------------------------------------------------
package hpcc_pkg;

  localparam int NUM_PLANES = 6;

  // field widths
  localparam int COORD_W = 16;              // Q11.4 point / corner, Q1.14 normal
  localparam int PIDX_W  = 3;               // plane index
  localparam int CFG_W   = 64;              // packed plane register
  localparam int CFG_IDX_W = 3;

  // datapath widths
  localparam int CR_W   = 33;               // cross product component
  localparam int OPB_W  = 34;               // wide multiplier operand
  localparam int PROD_W = COORD_W + OPB_W;  // multiplier result
  localparam int ACC_W  = 52;               // accumulator (det, numerator)
  localparam int FRAC_SH = 14;              // numerator scale to Q.4 quotient
  localparam int QUO_W  = 17;               // quotient magnitude bits

  // corner sequence length: 18 cross, 3 det, 9 numerator terms
  localparam int CORNER_STEPS = 30;

  typedef struct packed {
    logic signed [COORD_W-1:0] q;
    logic                      sat;
  } hpcc_div_res_t;

  typedef struct packed {
    logic [1:0] q;
    logic [1:0] r;
  } hpcc_div3_t;

  // small value split into quotient and remainder by three (0..8)
  function automatic hpcc_div3_t div3(input logic [3:0] v);
    hpcc_div3_t o;
    o.q = 2'd0;
    o.r = 2'd0;
    case (v)
      4'd0: begin o.q = 2'd0; o.r = 2'd0; end
      4'd1: begin o.q = 2'd0; o.r = 2'd1; end
      4'd2: begin o.q = 2'd0; o.r = 2'd2; end
      4'd3: begin o.q = 2'd1; o.r = 2'd0; end
      4'd4: begin o.q = 2'd1; o.r = 2'd1; end
      4'd5: begin o.q = 2'd1; o.r = 2'd2; end
      4'd6: begin o.q = 2'd2; o.r = 2'd0; end
      4'd7: begin o.q = 2'd2; o.r = 2'd1; end
      4'd8: begin o.q = 2'd2; o.r = 2'd2; end
      default: begin o.q = 2'd0; o.r = 2'd0; end
    endcase
    return o;
  endfunction

endpackage

// ----- src/hexahedron_plane_corner_and_containment_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexahedron_plane_corner_and_containment_top
// Point-in-hexahedron test and three-plane corner on one shared MAC unit
// plus a serial divider.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in_     | in_tvalid/in_tready   | tuser kind, tdata point and plane indices
//  out_    | out_tvalid/out_tready | tdata inside, corner, degenerate, saturated
//  cfg_    | cfg_valid/cfg_ready   | cfg_index, cfg_data (packed plane)
//
// Containment: the MAC sums n.p - d * 2^14 for each plane in turn.
// Corner: cross products, determinant and numerators on the MAC, then one
// division per coordinate (one quotient bit per cycle), skipped if degenerate.
// in_tready is high only when the sequencer is idle; the output register lets
// a new request start while a result waits. Synchronous active-low reset
// clears control state and the plane registers.
// ----------------------------------------------------------------------------
module hexahedron_plane_corner_and_containment_top
  import hpcc_pkg::*;
#(
  parameter int NUM_PLANES_P = NUM_PLANES
)(
  input  logic                 clk,
  input  logic                 rst_n,
  // requests
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // point_x, point_y, point_z, first,
                                           // second, third plane, zero pad
  input  logic                 in_tuser,   // kind
  // results
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata,  // inside_res, corner_x, corner_y,
                                           // corner_z, degenerate, saturated, pad
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CONT_STEPS = 4 * NUM_PLANES_P;
  localparam int MAX_STEPS  = (CONT_STEPS > CORNER_STEPS) ? CONT_STEPS : CORNER_STEPS;
  localparam int CNT_W      = $clog2(MAX_STEPS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DGO   = 3'd2;
  localparam logic [2:0] S_DWAIT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic KIND_POINT = 1'b0;

  // plane registers
  logic [CFG_W-1:0] plane_r [NUM_PLANES_P];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES_P; i++) plane_r[i] <= '0;
    end else if (cfg_valid && (32'(cfg_index) < NUM_PLANES_P)) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  // control and latched request
  logic [2:0]                 state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic [1:0]                 ci_r;
  logic                       kind_r;
  logic                       inside_r;
  logic signed [COORD_W-1:0]  pt_r   [3];
  logic signed [COORD_W-1:0]  nrm_r  [3][3];
  logic signed [COORD_W-1:0]  off_r  [3];
  logic signed [CR_W-1:0]     cr_r   [9];
  logic signed [ACC_W-1:0]    det_r;
  logic signed [ACC_W-1:0]    num_r  [3];
  logic signed [COORD_W-1:0]  cor_r  [3];
  logic                       sat_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic                       out_valid_r;
  logic [55:0]                out_data_r;

  logic                       accept;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // plane fetch by index; out-of-range reads an all-zero plane
  function automatic logic [CFG_W-1:0] plane_at(input logic [PIDX_W-1:0] idx,
                                                input logic [CFG_W-1:0] pl [NUM_PLANES_P]);
    logic [CFG_W-1:0] w;
    w = '0;
    for (int i = 0; i < NUM_PLANES_P; i++) begin
      if (32'(idx) == i) w = pl[i];
    end
    return w;
  endfunction

  // ---- MAC operand selection ----
  logic signed [COORD_W-1:0]  op_a;
  logic signed [OPB_W-1:0]    op_b;
  logic                       first, neg_t;
  logic                       st_cr, st_det, st_num, st_chk;
  logic [3:0]                 cr_sel;
  logic [1:0]                 num_sel;
  logic [CFG_W-1:0]           cplane;
  logic [CNT_W-3:0]           cpidx;
  hpcc_div3_t                 gk, ti;
  logic [1:0]                 ps, qs, k1, k2;
  logic [3:0]                 idx, s9;

  always_comb begin
    op_a = '0; op_b = '0; first = 1'b0; neg_t = 1'b0;
    st_cr = 1'b0; st_det = 1'b0; st_num = 1'b0; st_chk = 1'b0;
    cr_sel = '0; num_sel = '0;
    cpidx  = cnt_r[CNT_W-1:2];
    cplane = '0;
    if (32'(cpidx) < NUM_PLANES_P) cplane = plane_r[cpidx];
    idx = 4'(cnt_r >> 1);
    gk  = div3(idx);
    s9  = 4'(cnt_r - CNT_W'(21));
    ti  = div3(s9);
    ps = 2'd0; qs = 2'd0; k1 = 2'd0; k2 = 2'd0;
    if (kind_r == KIND_POINT) begin
      // n.p - d * 2^14, one plane per four steps
      case (cnt_r[1:0])
        2'd0: begin op_a = cplane[15:0];  op_b = OPB_W'(pt_r[0]); first = 1'b1; end
        2'd1: begin op_a = cplane[31:16]; op_b = OPB_W'(pt_r[1]); end
        2'd2: begin op_a = cplane[47:32]; op_b = OPB_W'(pt_r[2]); end
        default: begin
          op_a = cplane[63:48]; op_b = OPB_W'(1 << FRAC_SH); neg_t = 1'b1; st_chk = 1'b1;
        end
      endcase
    end else if (cnt_r < CNT_W'(18)) begin
      // cross products: (b,c), (c,a), (a,b)
      case (gk.q)
        2'd0:    begin ps = 2'd1; qs = 2'd2; end
        2'd1:    begin ps = 2'd2; qs = 2'd0; end
        default: begin ps = 2'd0; qs = 2'd1; end
      endcase
      case (gk.r)
        2'd0:    begin k1 = 2'd1; k2 = 2'd2; end
        2'd1:    begin k1 = 2'd2; k2 = 2'd0; end
        default: begin k1 = 2'd0; k2 = 2'd1; end
      endcase
      if (!cnt_r[0]) begin
        op_a = nrm_r[ps][k1]; op_b = OPB_W'(nrm_r[qs][k2]); first = 1'b1;
      end else begin
        op_a = nrm_r[ps][k2]; op_b = OPB_W'(nrm_r[qs][k1]); neg_t = 1'b1; st_cr = 1'b1;
      end
    end else if (cnt_r < CNT_W'(21)) begin
      // denominator a.n . (b x c)
      cr_sel = 4'(cnt_r - CNT_W'(18));
      op_a   = nrm_r[0][cr_sel[1:0]];
      op_b   = OPB_W'(cr_r[cr_sel]);
      first  = (cnt_r == CNT_W'(18));
      st_det = (cnt_r == CNT_W'(20));
    end else begin
      // numerator per coordinate, all terms negated
      num_sel = ti.q;
      cr_sel  = 4'(ti.r * 2'd3) + 4'(ti.q);
      op_a    = off_r[ti.r];
      op_b    = OPB_W'(cr_r[cr_sel]);
      neg_t   = 1'b1;
      first   = (ti.r == 2'd0);
      st_num  = (ti.r == 2'd2);
    end
  end

  // shared multiply-accumulate
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_base, acc_nxt;
  assign prod     = op_a * op_b;
  assign acc_base = first ? '0 : acc_r;
  assign acc_nxt  = neg_t ? acc_base - ACC_W'(prod) : acc_base + ACC_W'(prod);

  logic last_step;
  assign last_step = (kind_r == KIND_POINT) ? (cnt_r == CNT_W'(CONT_STEPS - 1))
                                            : (cnt_r == CNT_W'(CORNER_STEPS - 1));

  // divider
  logic          div_start, div_done;
  hpcc_div_res_t div_res;
  assign div_start = (state_r == S_DGO);

  hpcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r[ci_r]),
    .den   (det_r),
    .done  (div_done),
    .res   (div_res)
  );

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MAC;
      S_MAC: begin
        if (last_step) begin
          if (kind_r == KIND_POINT || det_r == '0) state_nxt = S_DONE;
          else state_nxt = S_DGO;
        end
      end
      S_DGO:   state_nxt = S_DWAIT;
      S_DWAIT: if (div_done) state_nxt = (ci_r == 2'd2) ? S_DONE : S_DGO;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [PIDX_W-1:0] pidx [3];
  logic [CFG_W-1:0]  pw   [3];
  assign pidx[0] = in_tdata[50:48];
  assign pidx[1] = in_tdata[53:51];
  assign pidx[2] = in_tdata[56:54];

  // selected planes for a corner request
  always_comb begin
    for (int j = 0; j < 3; j++) pw[j] = plane_at(pidx[j], plane_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_r   <= in_tuser;
          cnt_r    <= '0;
          ci_r     <= '0;
          inside_r <= 1'b1;
          sat_r    <= 1'b0;
          det_r    <= '0;
          pt_r[0]  <= in_tdata[15:0];
          pt_r[1]  <= in_tdata[31:16];
          pt_r[2]  <= in_tdata[47:32];
          for (int j = 0; j < 3; j++) begin
            nrm_r[j][0] <= pw[j][15:0];
            nrm_r[j][1] <= pw[j][31:16];
            nrm_r[j][2] <= pw[j][47:32];
            off_r[j]    <= pw[j][63:48];
            cor_r[j]    <= '0;
          end
        end
      end
      S_MAC: begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (st_chk && acc_nxt < 0) inside_r <= 1'b0;
        if (st_cr)  cr_r[idx] <= CR_W'(acc_nxt);
        if (st_det) det_r <= acc_nxt;
        if (st_num) num_r[num_sel] <= acc_nxt;
      end
      S_DWAIT: begin
        if (div_done) begin
          cor_r[ci_r] <= div_res.q;
          sat_r       <= sat_r | div_res.sat;
          ci_r        <= ci_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (kind_r == KIND_POINT)
            out_data_r <= {5'd0, 1'b0, 1'b0, 48'd0, inside_r};
          else
            out_data_r <= {5'd0, sat_r, (det_r == '0), cor_r[2], cor_r[1], cor_r[0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- src/hpcc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcc_div
// Restoring divider: (num * 2^14) / den, truncated toward zero, saturated
// to a signed 16-bit result. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module hpcc_div
  import hpcc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic signed [ACC_W-1:0] den,
  output logic                    done,
  output hpcc_div_res_t           res
);

  localparam int FULL_W = ACC_W + FRAC_SH;
  localparam int CNT_W  = $clog2(QUO_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [ACC_W-1:0]    rem_r;
  logic [ACC_W-1:0]    dmag_r;
  logic [QUO_W-1:0]    nsh_r;
  logic [QUO_W-1:0]    q_r;
  logic                neg_r;
  logic                ovf_r;

  logic [ACC_W-1:0]    nmag;
  logic [ACC_W-1:0]    dmag;
  logic [FULL_W-1:0]   nfull;
  logic [ACC_W:0]      r2;
  logic                ge;

  // operand magnitudes
  assign nmag  = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign dmag  = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
  assign nfull = {nmag, {FRAC_SH{1'b0}}};

  // one restoring step
  assign r2 = {rem_r, nsh_r[QUO_W-1]};
  assign ge = r2 >= {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= ACC_W'(nfull[FULL_W-1:QUO_W]);
        nsh_r  <= nfull[QUO_W-1:0];
        q_r    <= '0;
        dmag_r <= dmag;
        neg_r  <= num[ACC_W-1] ^ den[ACC_W-1];
        // quotient would not fit in QUO_W bits
        ovf_r  <= {{QUO_W{1'b0}}, nfull[FULL_W-1:QUO_W]} >= {{FRAC_SH{1'b0}}, dmag};
      end else if (busy_r) begin
        rem_r <= ge ? ACC_W'(r2 - {1'b0, dmag_r}) : r2[ACC_W-1:0];
        q_r   <= {q_r[QUO_W-2:0], ge};
        nsh_r <= {nsh_r[QUO_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // saturate: +32767 / -32768
  logic big_pos, big_neg;
  assign big_pos = !neg_r && (q_r > QUO_W'(32767));
  assign big_neg =  neg_r && (q_r > QUO_W'(32768));

  always_comb begin
    res.sat = ovf_r | big_pos | big_neg;
    if (res.sat) begin
      res.q = neg_r ? COORD_W'(16'sh8000) : COORD_W'(16'sh7fff);
    end else begin
      res.q = neg_r ? COORD_W'(-q_r) : COORD_W'(q_r);
    end
  end

  assign done = done_r;

endmodule
